// ----- rtl/cee_pkg.sv -----
package cee_pkg;

    localparam int MAX_TERMS = 32;
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);

    localparam logic signed [47:0] Q44_ONE = 48'sh1000_0000_0000;
    localparam logic signed [47:0] Q32_ONE = 48'sh0001_0000_0000;

    localparam logic signed [65:0] S48_MAX_W = 66'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [65:0] S48_MIN_W = -66'sh0_8000_0000_0000;

    typedef struct packed {
        logic [63:0]        eval_time;
        logic [63:0]        seg_start;
        logic [63:0]        seg_end;
        logic signed [63:0] coef_x;
        logic signed [63:0] coef_y;
        logic signed [63:0] coef_z;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] pos_x;
        logic signed [63:0] pos_y;
        logic signed [63:0] pos_z;
        logic signed [63:0] vel_x;
        logic signed [63:0] vel_y;
        logic signed [63:0] vel_z;
        logic               outside_segment;
    } t_out_item;

    typedef enum logic [2:0] {
        MOP_PT,
        MOP_DT,
        MOP_CP,
        MOP_CD,
        MOP_VS
    } t_mul_op;

    typedef enum logic {
        DIV_SCALE,
        DIV_NORM
    } t_div_sel;

    typedef struct packed {
        logic     div_start;
        t_div_sel div_sel;
        logic     norm_set;
        logic     phase1_set;
        logic     recur_set;
        logic     mul_start;
        t_mul_op  mul_op;
        logic [1:0] axis;
        logic     hist;
        logic     hist_shift;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic mul_done;
        logic last;
        logic out_free;
    } t_stat;

    function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
        logic signed [47:0] r;
        if (v > S48_MAX_W) begin
            r = S48_MAX_W[47:0];
        end else if (v < S48_MIN_W) begin
            r = S48_MIN_W[47:0];
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        logic signed [63:0] r;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            r = s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end else begin
            r = s[63:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/chebyshev_ephemeris_eval.sv -----
// Chebyshev ephemeris record evaluator, position and velocity of one body.
// Input channel: i_valid / o_stall carry one coefficient triple per item, in
// index order from zero; the first item of a run also supplies the epoch and
// the record interval. The item with last set closes the run.
// Output channel: o_valid / i_stall carry one result per run, with position,
// scaled velocity and the outside-segment flag.
// Work is done one item at a time on one shared multiplier (four 32x32
// partial products) and one bit-serial divider, which skips the iteration
// when the quotient overflows. A first item takes two divisions plus six
// products, a second six products, later items two more products for the
// recurrence, and items beyond the term limit none. A last item adds the
// velocity scaling (three products) and a claim of the result register,
// which is loaded in the following cycle.
// The result register frees the input side: the next item is taken while a
// result still waits. If the receiver stalls with a result held, a further
// last item waits until that result has been taken.
// Reset (synchronous, active low) clears all sums and starts a new run.
module chebyshev_ephemeris_eval
    import cee_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    logic  busy, accept;
    t_cmd  cmd;
    t_stat stat;

    assign o_stall = busy;
    assign accept  = i_valid && !busy;

    cee_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_stat   (stat),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    cee_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_item  (i_item),
        .i_cmd   (cmd),
        .i_stall (i_stall),
        .o_stat  (stat),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

endmodule

// ----- rtl/cee_mul.sv -----
module cee_mul
    import cee_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    input  logic               i_sh32,
    output logic               o_done,
    output logic signed [63:0] o_result
);

    logic [63:0]  r_ua, r_ub;
    logic         r_neg, r_sh32;
    logic [127:0] r_acc;
    logic [63:0]  r_pp;
    logic [1:0]   r_pp_sel;
    logic [2:0]   r_cnt;
    logic         r_busy, r_done;
    logic signed [63:0] r_res;

    logic [31:0]  a_half, b_half;
    logic [127:0] pp_ext;
    logic [63:0]  sh_lo, lim, sat_lo;
    logic         sh_hi_nz;

    assign a_half = r_cnt[0] ? r_ua[63:32] : r_ua[31:0];
    assign b_half = r_cnt[1] ? r_ub[63:32] : r_ub[31:0];

    always_comb begin
        case (r_pp_sel)
            2'd0:    pp_ext = {64'b0, r_pp};
            2'd3:    pp_ext = {r_pp, 64'b0};
            default: pp_ext = {32'b0, r_pp, 32'b0};
        endcase
    end

    // Drop the fraction bits, then clamp the magnitude to what the sign allows.
    always_comb begin
        if (r_sh32) begin
            sh_lo    = r_acc[95:32];
            sh_hi_nz = |r_acc[127:96];
        end else begin
            sh_lo    = r_acc[107:44];
            sh_hi_nz = |r_acc[127:108];
        end
        lim    = r_neg ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        sat_lo = (sh_hi_nz || sh_lo > lim) ? lim : sh_lo;
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (i_start) begin
            r_ua   <= i_a[63] ? ~i_a + 64'd1 : i_a;
            r_ub   <= i_b[63] ? ~i_b + 64'd1 : i_b;
            r_neg  <= i_a[63] ^ i_b[63];
            r_sh32 <= i_sh32;
            r_acc  <= '0;
            r_cnt  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 3'd1;
            if (r_cnt < 3'd4) begin
                r_pp     <= a_half * b_half;
                r_pp_sel <= r_cnt[1:0];
            end
            if (r_cnt >= 3'd1 && r_cnt <= 3'd4) begin
                r_acc <= r_acc + pp_ext;
            end
            if (r_cnt == 3'd5) begin
                r_res  <= r_neg ? ~sat_lo + 64'd1 : sat_lo;
                r_done <= 1'b1;
                r_busy <= 1'b0;
            end
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// ----- rtl/cee_div.sv -----
module cee_div
    import cee_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_hi,
    input  logic [63:0] i_lo,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quot
);

    logic [63:0] r_rem, r_lo, r_den, r_q;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;

    logic [63:0] shifted;
    logic        carry, take;

    assign carry   = r_rem[63];
    assign shifted = {r_rem[62:0], r_lo[63]};
    assign take    = carry || (shifted >= r_den);

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (i_start) begin
            if (i_hi >= i_den) begin
                // Quotient would not fit in 64 bits.
                r_q    <= '1;
                r_done <= 1'b1;
            end else begin
                r_rem  <= i_hi;
                r_lo   <= i_lo;
                r_den  <= i_den;
                r_q    <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end
        end else if (r_busy) begin
            r_rem <= take ? shifted - r_den : shifted;
            r_q   <= {r_q[62:0], take};
            r_lo  <= {r_lo[62:0], 1'b0};
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ----- rtl/cee_datapath.sv -----
module cee_datapath
    import cee_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_in_item  i_item,
    input  t_cmd      i_cmd,
    input  logic      i_stall,
    output t_stat     o_stat,
    output logic      o_valid,
    output t_out_item o_item
);

    t_in_item r_in;
    logic signed [47:0] r_norm, r_poly_last, r_poly_before, r_deriv_last, r_deriv_before;
    logic signed [47:0] r_tp, r_td;
    logic [47:0]        r_vel_scale;
    logic               r_range;
    logic [63:0]        r_quot;
    logic signed [63:0] r_m, r_n;
    logic signed [63:0] r_pos [3];
    logic signed [63:0] r_vel [3];
    logic signed [63:0] r_vout [3];
    t_mul_op            r_op;
    logic [1:0]         r_axis;
    t_div_sel           r_div_sel;
    t_out_item          r_out;
    logic               r_ovalid;

    logic        below, ordered;
    logic [63:0] iv, gap, div_hi, div_lo, div_quot;
    logic        div_done, mul_done;
    logic signed [63:0] mul_a, mul_b, mul_res, coef_sel;
    logic               mul_sh32;

    logic [47:0]        s_clamp;
    logic signed [50:0] norm_w;
    logic signed [65:0] tp_w, td_w;
    logic signed [47:0] pl_q;

    assign below   = r_in.eval_time < r_in.seg_start;
    assign ordered = r_in.seg_end > r_in.seg_start;
    assign iv      = ordered ? r_in.seg_end - r_in.seg_start : 64'd1;
    assign gap     = below ? r_in.seg_start - r_in.eval_time
                           : r_in.eval_time - r_in.seg_start;

    always_comb begin
        if (i_cmd.div_sel == DIV_SCALE) begin
            div_hi = 64'd2;
            div_lo = 64'd0;
        end else begin
            div_hi = {20'b0, gap[63:20]};
            div_lo = {gap[19:0], 44'b0};
        end
    end

    cee_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_hi    (div_hi),
        .i_lo    (div_lo),
        .i_den   (iv),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        case (i_cmd.axis)
            2'd0:    coef_sel = r_in.coef_x;
            2'd1:    coef_sel = r_in.coef_y;
            default: coef_sel = r_in.coef_z;
        endcase
    end

    always_comb begin
        case (i_cmd.mul_op)
            MOP_PT: begin
                mul_a    = {{16{r_norm[47]}}, r_norm};
                mul_b    = {{16{r_poly_last[47]}}, r_poly_last};
                mul_sh32 = 1'b0;
            end
            MOP_DT: begin
                mul_a    = {{16{r_norm[47]}}, r_norm};
                mul_b    = {{16{r_deriv_last[47]}}, r_deriv_last};
                mul_sh32 = 1'b0;
            end
            MOP_CP: begin
                mul_a    = coef_sel;
                mul_b    = {{16{r_tp[47]}}, r_tp};
                mul_sh32 = 1'b0;
            end
            MOP_CD: begin
                mul_a    = coef_sel;
                mul_b    = {{16{r_td[47]}}, r_td};
                mul_sh32 = 1'b1;
            end
            default: begin
                mul_a    = r_vel[i_cmd.axis];
                mul_b    = {16'b0, r_vel_scale};
                mul_sh32 = 1'b1;
            end
        endcase
    end

    cee_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.mul_start),
        .i_a      (mul_a),
        .i_b      (mul_b),
        .i_sh32   (mul_sh32),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    // t = 2*(eval - start)/interval - 1, with the quotient clamped at 8.
    always_comb begin
        s_clamp = (r_quot > 64'h0000_8000_0000_0000) ? 48'h8000_0000_0000 : r_quot[47:0];
        if (below) begin
            norm_w = -$signed({2'b00, s_clamp, 1'b0}) - 51'sh1000_0000_0000;
        end else begin
            norm_w = $signed({2'b00, s_clamp, 1'b0}) - 51'sh1000_0000_0000;
        end
    end

    // Division of T[n-1] by 4096 rounds toward zero.
    always_comb begin
        pl_q = r_poly_last >>> 12;
        if (r_poly_last[47] && (r_poly_last[11:0] != 12'd0)) begin
            pl_q = pl_q + 48'sd1;
        end
        tp_w = ({{2{r_m[63]}}, r_m} <<< 1) - {{18{r_poly_before[47]}}, r_poly_before};
        td_w = ({{2{r_n[63]}}, r_n} <<< 1) + ({{18{pl_q[47]}}, pl_q} <<< 1)
             - {{18{r_deriv_before[47]}}, r_deriv_before};
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_in <= i_item;
        end
        if (i_cmd.div_start) begin
            r_div_sel <= i_cmd.div_sel;
        end
        if (div_done) begin
            if (r_div_sel == DIV_SCALE) begin
                r_vel_scale <= (div_quot[63:48] != 16'd0) ? '1 : div_quot[47:0];
            end else begin
                r_quot <= div_quot;
            end
        end
        if (i_cmd.mul_start) begin
            r_op   <= i_cmd.mul_op;
            r_axis <= i_cmd.axis;
        end
        if (mul_done) begin
            case (r_op)
                MOP_PT:  r_m <= mul_res;
                MOP_DT:  r_n <= mul_res;
                MOP_CP:  r_pos[r_axis] <= sat_add64(r_pos[r_axis], mul_res);
                MOP_CD:  r_vel[r_axis] <= sat_add64(r_vel[r_axis], mul_res);
                default: r_vout[r_axis] <= mul_res;
            endcase
        end
        if (i_cmd.norm_set) begin
            r_norm         <= sat48({{15{norm_w[50]}}, norm_w});
            r_range        <= below || (r_in.eval_time > r_in.seg_end) || !ordered;
            r_tp           <= Q44_ONE;
            r_td           <= '0;
            r_poly_before  <= '0;
            r_deriv_before <= '0;
            for (int k = 0; k < 3; k++) begin
                r_pos[k] <= '0;
                r_vel[k] <= '0;
            end
        end
        if (i_cmd.phase1_set) begin
            r_tp <= r_norm;
            r_td <= Q32_ONE;
        end
        if (i_cmd.recur_set) begin
            r_tp <= sat48(tp_w);
            r_td <= sat48(td_w);
        end
        if (i_cmd.hist) begin
            if (i_cmd.hist_shift) begin
                r_poly_before  <= r_poly_last;
                r_deriv_before <= r_deriv_last;
            end
            r_poly_last  <= r_tp;
            r_deriv_last <= r_td;
        end
        if (r_ovalid && !i_stall) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out.pos_x           <= r_pos[0];
            r_out.pos_y           <= r_pos[1];
            r_out.pos_z           <= r_pos[2];
            r_out.vel_x           <= r_vout[0];
            r_out.vel_y           <= r_vout[1];
            r_out.vel_z           <= r_vout[2];
            r_out.outside_segment <= r_range;
            r_ovalid              <= 1'b1;
        end
        if (!i_rst_n) begin
            r_ovalid       <= 1'b0;
            r_norm         <= '0;
            r_vel_scale    <= '0;
            r_range        <= 1'b0;
            r_poly_last    <= '0;
            r_poly_before  <= '0;
            r_deriv_last   <= '0;
            r_deriv_before <= '0;
            for (int k = 0; k < 3; k++) begin
                r_pos[k] <= '0;
                r_vel[k] <= '0;
            end
        end
    end

    assign o_stat.div_done = div_done;
    assign o_stat.mul_done = mul_done;
    assign o_stat.last     = r_in.last;
    assign o_stat.out_free = !r_ovalid || !i_stall;
    assign o_valid         = r_ovalid;
    assign o_item          = r_out;

endmodule

// ----- rtl/cee_ctrl.sv -----
module cee_ctrl
    import cee_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  t_stat i_stat,
    output logic  o_busy,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_SCALE,
        S_DIV_NORM,
        S_NORM,
        S_PHASE1,
        S_REC_M,
        S_REC_N,
        S_RECUR,
        S_ACC,
        S_HIST,
        S_END,
        S_VEL,
        S_EMIT
    } t_state;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_LATER  = 2'd2;

    t_state           r_state;
    logic             r_wait;
    logic [1:0]       r_axis;
    logic             r_velsel;
    logic [1:0]       r_phase;
    logic [CNT_W-1:0] r_count;
    t_cmd             r_cmd;

    always_ff @(posedge i_clk) begin
        r_cmd <= '0;
        case (r_state)
            S_IDLE: begin
                r_wait   <= 1'b0;
                r_axis   <= '0;
                r_velsel <= 1'b0;
                if (i_accept) begin
                    if (r_phase == PH_FIRST) begin
                        r_state <= S_DIV_SCALE;
                    end else if (r_count >= CNT_W'(MAX_TERMS)) begin
                        r_state <= S_END;
                    end else if (r_phase == PH_SECOND) begin
                        r_state <= S_PHASE1;
                    end else begin
                        r_state <= S_REC_M;
                    end
                end
            end
            S_DIV_SCALE, S_DIV_NORM: begin
                if (!r_wait) begin
                    r_cmd.div_start <= 1'b1;
                    r_cmd.div_sel   <= (r_state == S_DIV_SCALE) ? DIV_SCALE : DIV_NORM;
                    r_wait          <= 1'b1;
                end else if (i_stat.div_done) begin
                    r_wait  <= 1'b0;
                    r_state <= (r_state == S_DIV_SCALE) ? S_DIV_NORM : S_NORM;
                end
            end
            S_NORM: begin
                r_cmd.norm_set <= 1'b1;
                r_state        <= S_ACC;
            end
            S_PHASE1: begin
                r_cmd.phase1_set <= 1'b1;
                r_state          <= S_ACC;
            end
            S_REC_M, S_REC_N: begin
                if (!r_wait) begin
                    r_cmd.mul_start <= 1'b1;
                    r_cmd.mul_op    <= (r_state == S_REC_M) ? MOP_PT : MOP_DT;
                    r_wait          <= 1'b1;
                end else if (i_stat.mul_done) begin
                    r_wait  <= 1'b0;
                    r_state <= (r_state == S_REC_M) ? S_REC_N : S_RECUR;
                end
            end
            S_RECUR: begin
                r_cmd.recur_set <= 1'b1;
                r_state         <= S_ACC;
            end
            S_ACC: begin
                // Position then velocity term for each axis in turn.
                if (!r_wait) begin
                    r_cmd.mul_start <= 1'b1;
                    r_cmd.mul_op    <= r_velsel ? MOP_CD : MOP_CP;
                    r_cmd.axis      <= r_axis;
                    r_wait          <= 1'b1;
                end else if (i_stat.mul_done) begin
                    r_wait <= 1'b0;
                    if (!r_velsel) begin
                        r_velsel <= 1'b1;
                    end else begin
                        r_velsel <= 1'b0;
                        if (r_axis == 2'd2) begin
                            r_state <= S_HIST;
                        end else begin
                            r_axis <= r_axis + 2'd1;
                        end
                    end
                end
            end
            S_HIST: begin
                r_cmd.hist       <= 1'b1;
                r_cmd.hist_shift <= (r_count != '0);
                r_count          <= r_count + CNT_W'(1);
                r_phase          <= (r_phase == PH_FIRST) ? PH_SECOND : PH_LATER;
                r_state          <= S_END;
            end
            S_END: begin
                r_axis  <= '0;
                r_state <= i_stat.last ? S_VEL : S_IDLE;
            end
            S_VEL: begin
                if (!r_wait) begin
                    r_cmd.mul_start <= 1'b1;
                    r_cmd.mul_op    <= MOP_VS;
                    r_cmd.axis      <= r_axis;
                    r_wait          <= 1'b1;
                end else if (i_stat.mul_done) begin
                    r_wait <= 1'b0;
                    if (r_axis == 2'd2) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_axis <= r_axis + 2'd1;
                    end
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    r_cmd.out_load <= 1'b1;
                    r_phase        <= PH_FIRST;
                    r_count        <= '0;
                    r_state        <= S_IDLE;
                end
            end
            default: begin
                r_state <= S_IDLE;
            end
        endcase
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
            r_phase <= PH_FIRST;
            r_count <= '0;
            r_cmd   <= '0;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_cmd  = r_cmd;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_TERMS))
        else $error("term count beyond limit");

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_cmd.mul_start && r_cmd.div_start))
        else $error("multiplier and divider started together");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd.out_load |-> (r_state == S_IDLE && r_phase == PH_FIRST))
        else $error("result loaded without closing the run");

    a_phase_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FIRST) |-> (r_count == '0))
        else $error("count left over at start of run");
`endif

endmodule
